// File: rtl/core/rau_pkg.sv
// ----------------------------------------------------------------------------
// rau_pkg: shared definitions for the rational arithmetic unit
// Operation and status codes and datapath widths.
// ----------------------------------------------------------------------------
package rau_pkg;

    localparam int VALUE_WIDTH_DEF = 32;
    localparam int MAG_W = 64;

    localparam logic [2:0] OP_ADD = 3'd0;
    localparam logic [2:0] OP_SUB = 3'd1;
    localparam logic [2:0] OP_MUL = 3'd2;
    localparam logic [2:0] OP_DIV = 3'd3;
    localparam logic [2:0] OP_EQ  = 3'd4;

    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_DIVZERO  = 2'd1;
    localparam logic [1:0] ST_OVERFLOW = 2'd2;

endpackage

// File: rtl/core/rau_divider.sv
// ----------------------------------------------------------------------------
// rau_divider: shared restoring divider
// Unsigned 64-bit quotient and remainder, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module rau_divider
    import rau_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  logic [MAG_W-1:0] dividend,
    input  logic [MAG_W-1:0] divisor,
    output logic             done,
    output logic [MAG_W-1:0] quotient,
    output logic [MAG_W-1:0] remainder
);

    localparam int CNT_W = $clog2(MAG_W + 1);

    logic [MAG_W-1:0] quo_reg;
    logic [MAG_W-1:0] rem_reg;
    logic [MAG_W-1:0] dvs_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic             run_reg;
    logic             done_reg;
    logic [MAG_W:0]   trial;
    logic [MAG_W:0]   shifted;

    assign shifted = {rem_reg, quo_reg[MAG_W-1]};
    assign trial   = shifted - {1'b0, dvs_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                run_reg <= 1'b1;
                cnt_reg <= CNT_W'(MAG_W);
            end
            else if (run_reg)
            begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == CNT_W'(1))
                begin
                    run_reg  <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            quo_reg <= dividend;
            rem_reg <= '0;
            dvs_reg <= divisor;
        end
        else if (run_reg)
        begin
            if (!trial[MAG_W])
            begin
                rem_reg <= trial[MAG_W-1:0];
                quo_reg <= {quo_reg[MAG_W-2:0], 1'b1};
            end
            else
            begin
                rem_reg <= shifted[MAG_W-1:0];
                quo_reg <= {quo_reg[MAG_W-2:0], 1'b0};
            end
        end
    end

    assign done      = done_reg;
    assign quotient  = quo_reg;
    assign remainder = rem_reg;

endmodule

// File: rtl/core/rational_arithmetic_unit.sv
// Sequence: compare and reserved codes end at S_M0; add and subtract use S_M1 too,
// multiply and divide skip it; unless the denominator is zero, Euclid gcd and reduction follow.
// Throughput: one transaction at a time; busy holds until the result strobe.
// The multiplier is shared by states S_M0, S_M1 and S_M2; all division uses one divider.
// Reset: asynchronous, active low; clears the sequencer and the strobe.
// The receiver cannot stall; each result is shown for exactly one cycle.
// ----------------------------------------------------------------------------
// rational_arithmetic_unit: reduced fraction add, subtract, multiply, divide, compare
// Cross products, sign fix, Euclid gcd and reduction under a small sequencer.
// ----------------------------------------------------------------------------
module rational_arithmetic_unit
    import rau_pkg::*;
#(
    parameter int VALUE_WIDTH = VALUE_WIDTH_DEF
)
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    output logic                          busy,
    input  logic [2:0]                    operation,
    input  logic signed [VALUE_WIDTH-1:0] a_num,
    input  logic [VALUE_WIDTH-2:0]        a_den,
    input  logic signed [VALUE_WIDTH-1:0] b_num,
    input  logic [VALUE_WIDTH-2:0]        b_den,
    output logic                          strobe,
    output logic signed [VALUE_WIDTH-1:0] res_num,
    output logic [VALUE_WIDTH-2:0]        res_den,
    output logic                          equal,
    output logic [1:0]                    status
);

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_M0    = 4'd1;
    localparam logic [3:0] S_M1    = 4'd2;
    localparam logic [3:0] S_M2    = 4'd3;
    localparam logic [3:0] S_M3    = 4'd4;
    localparam logic [3:0] S_PREP  = 4'd5;
    localparam logic [3:0] S_GCD   = 4'd6;
    localparam logic [3:0] S_GWAIT = 4'd7;
    localparam logic [3:0] S_DN    = 4'd8;
    localparam logic [3:0] S_DNW   = 4'd9;
    localparam logic [3:0] S_DD    = 4'd10;
    localparam logic [3:0] S_DDW   = 4'd11;
    localparam logic [3:0] S_CHK   = 4'd12;

    localparam logic [MAG_W-1:0] LIM = MAG_W'(1) << (VALUE_WIDTH - 1);

    logic [3:0]                    state_reg;
    logic [2:0]                    op_reg;
    logic signed [VALUE_WIDTH-1:0] an_reg, bn_reg;
    logic [VALUE_WIDTH-2:0]        ad_reg, bd_reg;
    logic signed [MAG_W-1:0]       p_reg;
    logic signed [MAG_W-1:0]       n_reg;
    logic signed [MAG_W-1:0]       d_reg;
    logic [MAG_W-1:0]              x_reg, y_reg;
    logic [MAG_W-1:0]              nm_reg, dm_reg;
    logic                          neg_reg;
    logic                          strobe_reg;
    logic signed [VALUE_WIDTH-1:0] rn_reg;
    logic [VALUE_WIDTH-2:0]        rd_reg;
    logic                          eq_reg;
    logic [1:0]                    st_reg;

    logic signed [VALUE_WIDTH:0]     mul_a, mul_b;
    logic signed [2*VALUE_WIDTH+1:0] mul_full;
    logic signed [MAG_W-1:0]         mul_p;
    logic                            div_start;
    logic                            div_done;
    logic [MAG_W-1:0]                div_n, div_d, div_q, div_r;

    function automatic logic signed [VALUE_WIDTH:0] b_num_ext(
        input logic signed [VALUE_WIDTH-1:0] v);
        b_num_ext = {v[VALUE_WIDTH-1], v};
    endfunction

    function automatic logic [VALUE_WIDTH-1:0] bd_ext(input logic [VALUE_WIDTH-2:0] v);
        bd_ext = {1'b0, v};
    endfunction

    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        case (state_reg)
            S_M0:
            begin
                mul_a = b_num_ext(an_reg);
                mul_b = (op_reg == OP_MUL) ? {b_num_ext(bn_reg)} : {1'b0, bd_ext(bd_reg)};
            end
            S_M1:
            begin
                mul_a = b_num_ext(bn_reg);
                mul_b = {1'b0, bd_ext(ad_reg)};
            end
            S_M2:
            begin
                mul_a = {1'b0, bd_ext(ad_reg)};
                mul_b = (op_reg == OP_DIV) ? b_num_ext(bn_reg) : {1'b0, bd_ext(bd_reg)};
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign mul_full = mul_a * mul_b;
    assign mul_p    = MAG_W'(mul_full);

    rau_divider u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (div_start),
        .dividend  (div_n),
        .divisor   (div_d),
        .done      (div_done),
        .quotient  (div_q),
        .remainder (div_r)
    );

    always_comb
    begin
        div_start = (state_reg == S_GCD && y_reg != '0) || state_reg == S_DN
                    || state_reg == S_DD;
        div_n = (state_reg == S_DD) ? dm_reg : ((state_reg == S_DN) ? nm_reg : x_reg);
        div_d = (state_reg == S_GCD) ? y_reg : x_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            strobe_reg <= 1'b0;
        end
        else
        begin
            strobe_reg <= 1'b0;
            case (state_reg)
                S_IDLE:
                    if (start)
                        state_reg <= S_M0;
                S_M0:
                begin
                    if (op_reg == OP_EQ || op_reg > OP_DIV)
                    begin
                        state_reg  <= S_IDLE;
                        strobe_reg <= 1'b1;
                    end
                    else if (op_reg == OP_MUL || op_reg == OP_DIV)
                        state_reg <= S_M2;
                    else
                        state_reg <= S_M1;
                end
                S_M1:    state_reg <= S_M2;
                S_M2:    state_reg <= S_M3;
                S_M3:
                begin
                    if (d_reg == '0)
                    begin
                        state_reg  <= S_IDLE;
                        strobe_reg <= 1'b1;
                    end
                    else
                        state_reg <= S_PREP;
                end
                S_PREP:  state_reg <= S_GCD;
                S_GCD:   state_reg <= (y_reg == '0) ? S_DN : S_GWAIT;
                S_GWAIT: if (div_done) state_reg <= S_GCD;
                S_DN:    state_reg <= S_DNW;
                S_DNW:   if (div_done) state_reg <= S_DD;
                S_DD:    state_reg <= S_DDW;
                S_DDW:   if (div_done) state_reg <= S_CHK;
                S_CHK:
                begin
                    state_reg  <= S_IDLE;
                    strobe_reg <= 1'b1;
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        case (state_reg)
            S_IDLE:
                if (start)
                begin
                    op_reg <= operation;
                    an_reg <= a_num;
                    ad_reg <= a_den;
                    bn_reg <= b_num;
                    bd_reg <= b_den;
                end
            S_M0:
            begin
                p_reg  <= mul_p;
                n_reg  <= mul_p;
                rn_reg <= '0;
                rd_reg <= '0;
                st_reg <= ST_OK;
                eq_reg <= (op_reg == OP_EQ) && (an_reg == bn_reg) && (ad_reg == bd_reg);
            end
            S_M1:
                n_reg <= (op_reg == OP_SUB) ? p_reg - mul_p : p_reg + mul_p;
            S_M2:
                d_reg <= mul_p;
            S_M3:
                if (d_reg == '0)
                    st_reg <= ST_DIVZERO;
            S_PREP:
            begin
                nm_reg  <= n_reg[MAG_W-1] ? -n_reg : n_reg;
                dm_reg  <= d_reg[MAG_W-1] ? -d_reg : d_reg;
                x_reg   <= n_reg[MAG_W-1] ? -n_reg : n_reg;
                y_reg   <= d_reg[MAG_W-1] ? -d_reg : d_reg;
                neg_reg <= (n_reg != '0) && (n_reg[MAG_W-1] != d_reg[MAG_W-1]);
            end
            S_GWAIT:
                if (div_done)
                begin
                    x_reg <= y_reg;
                    y_reg <= div_r;
                end
            S_DNW:
                if (div_done)
                    nm_reg <= div_q;
            S_DDW:
                if (div_done)
                    dm_reg <= div_q;
            S_CHK:
                if (dm_reg > LIM - 1'b1 || (neg_reg ? nm_reg > LIM : nm_reg > LIM - 1'b1))
                    st_reg <= ST_OVERFLOW;
                else
                begin
                    rn_reg <= VALUE_WIDTH'(neg_reg ? -nm_reg : nm_reg);
                    rd_reg <= dm_reg[VALUE_WIDTH-2:0];
                end
            default:
            begin
            end
        endcase
    end

    assign busy    = (state_reg != S_IDLE);
    assign strobe  = strobe_reg;
    assign res_num = rn_reg;
    assign res_den = rd_reg;
    assign equal   = eq_reg;
    assign status  = st_reg;

`ifndef SYNTHESIS
    a_start_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> busy)
        else $error("busy not raised after accepted transaction");
    a_strobe_idle: assert property (@(posedge clk) disable iff (!rst_n)
        strobe |-> !busy)
        else $error("result strobe while busy");
    a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (strobe && status != ST_OK) |-> (res_num == '0 && res_den == '0 && !equal))
        else $error("non-zero payload with error status");
`endif

endmodule
